// ----- sv/pbr_pkg.sv -----
package pbr_pkg;

  localparam int PAGES  = 128;
  localparam int PW     = $clog2(PAGES + 1);
  localparam int SHW    = 5;
  localparam int RUN_W  = 24;
  localparam int PATH_W = 16;
  localparam int OFF_W  = 32;

  localparam logic [SHW-1:0] SH_MIN = SHW'(9);
  localparam logic [SHW-1:0] SH_MAX = SHW'(16);
  localparam logic [SHW-1:0] SH_RST = SHW'(12);

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_MARK  = 2'd1;
  localparam logic [1:0] REQ_ISECT = 2'd2;
  localparam logic [1:0] REQ_EMIT  = 2'd3;

  localparam logic [1:0] MAP_A = 2'd0;
  localparam logic [1:0] MAP_B = 2'd1;
  localparam logic [1:0] MAP_C = 2'd2;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_MARK,
    OP_ISECT,
    OP_EMIT,
    OP_NOMAP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [1:0]        sel;
    logic [PW-1:0]     start;
    logic [PW-1:0]     stop;
    logic [PW-1:0]     endp;
    logic              ovf;
    logic [PATH_W-1:0] path;
    logic [SHW-1:0]    shift;
  } cmd_t;

  // bit i set for every page i below k
  function automatic logic [PAGES-1:0] thermo(input logic [PW-1:0] k);
    logic [PAGES-1:0] m;
    for (int i = 0; i < PAGES; i++) begin
      m[i] = (32'(i) < 32'(k));
    end
    return m;
  endfunction

  // index of the single set bit of a one-hot vector
  function automatic logic [PW-1:0] onehot_idx(input logic [PAGES:0] v);
    logic [PW-1:0] r;
    r = '0;
    for (int i = 0; i <= PAGES; i++) begin
      if (v[i]) r = r | PW'(i);
    end
    return r;
  endfunction

endpackage

// ----- sv/page_bitmap_range_engine.sv -----
// channel   | handshake               | word
// ----------+-------------------------+------------------------------------------------
// config    | cfg_we_i                | cfg_wdata_i (page_shift)
// request   | in_valid_i / in_stall_o | req_type, map_sel, byte_offset, byte_length, path
// result    | out_valid_o/out_stall_i | run_offset, run_length, run_path, run_valid,
//           |                         | last, map_empty, overflow
//
// A request is decoded combinationally into a two-word queue; the back end then takes one
// queued word per cycle while it is idle and its result register is free. Clear, mark and
// intersect give their status word one cycle after leaving the queue. Emit scans the map
// run by run: it first finds the run, then sends it.
// Reset empties all three maps, zeroes their sizes and sets page_shift to 12; no sweep.
// in_stall_o rises when the queue is full; a stalled result word holds in its register.
module page_bitmap_range_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pbr_pkg::SHW-1:0]    cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [1:0]                 map_sel_i,
  input  logic [pbr_pkg::OFF_W-1:0]  byte_offset_i,
  input  logic [pbr_pkg::OFF_W-1:0]  byte_length_i,
  input  logic [pbr_pkg::PATH_W-1:0] path_index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pbr_pkg::RUN_W-1:0]  run_offset_o,
  output logic [pbr_pkg::RUN_W-1:0]  run_length_o,
  output logic [pbr_pkg::PATH_W-1:0] run_path_o,
  output logic                       run_valid_o,
  output logic                       last_o,
  output logic                       map_empty_o,
  output logic                       overflow_o
);
  import pbr_pkg::*;

  logic q_full, q_empty, push, pop;
  cmd_t cmd_in, cmd_out;

  pbr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .map_sel_i     (map_sel_i),
    .byte_offset_i (byte_offset_i),
    .byte_length_i (byte_length_i),
    .path_index_i  (path_index_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  pbr_cmd_q u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .empty_o (q_empty)
  );

  pbr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .cmd_i        (cmd_out),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .run_offset_o (run_offset_o),
    .run_length_o (run_length_o),
    .run_path_o   (run_path_o),
    .run_valid_o  (run_valid_o),
    .last_o       (last_o),
    .map_empty_o  (map_empty_o),
    .overflow_o   (overflow_o)
  );

endmodule

// ----- sv/pbr_front.sv -----
module pbr_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pbr_pkg::SHW-1:0]    cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [1:0]                 map_sel_i,
  input  logic [pbr_pkg::OFF_W-1:0]  byte_offset_i,
  input  logic [pbr_pkg::OFF_W-1:0]  byte_length_i,
  input  logic [pbr_pkg::PATH_W-1:0] path_index_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output pbr_pkg::cmd_t              cmd_o
);
  import pbr_pkg::*;

  logic [SHW-1:0]   shift_q, shift_d;
  logic [SHW-1:0]   sh;
  logic [OFF_W-1:0] start, lpg;
  logic [OFF_W:0]   stop, sum, endp;
  logic             map_ok;

  always_comb begin
    shift_d = cfg_we_i ? cfg_wdata_i : shift_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SH_RST;
    end else begin
      shift_q <= shift_d;
    end
  end

  always_comb begin
    if (shift_q < SH_MIN) sh = SH_MIN;
    else if (shift_q > SH_MAX) sh = SH_MAX;
    else sh = shift_q;
  end

  assign start = byte_offset_i >> sh;
  assign lpg   = byte_length_i >> sh;
  assign stop  = {1'b0, start} + {1'b0, lpg};
  assign sum   = {1'b0, byte_offset_i} + {1'b0, byte_length_i};
  assign endp  = sum >> sh;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    map_ok = map_sel_i inside {MAP_A, MAP_B, MAP_C};
    cmd_o.sel   = map_sel_i;
    cmd_o.path  = path_index_i;
    cmd_o.shift = sh;
    cmd_o.start = (start > OFF_W'(PAGES)) ? PW'(PAGES) : start[PW-1:0];
    cmd_o.stop  = (stop > (OFF_W+1)'(PAGES)) ? PW'(PAGES) : stop[PW-1:0];
    cmd_o.endp  = (endp > (OFF_W+1)'(PAGES)) ? PW'(PAGES) : endp[PW-1:0];
    cmd_o.ovf   = (stop > (OFF_W+1)'(PAGES)) || (endp > (OFF_W+1)'(PAGES));
    case (req_type_i)
      REQ_CLEAR: cmd_o.op = map_ok ? OP_CLEAR : OP_NOMAP;
      REQ_MARK:  cmd_o.op = map_ok ? OP_MARK : OP_NOMAP;
      REQ_ISECT: cmd_o.op = OP_ISECT;
      REQ_EMIT:  cmd_o.op = map_ok ? OP_EMIT : OP_NOMAP;
      default:   cmd_o.op = OP_NOMAP;
    endcase
  end

endmodule

// ----- sv/pbr_cmd_q.sv -----
module pbr_cmd_q (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pbr_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output pbr_pkg::cmd_t data_o,
  output logic          empty_o
);
  import pbr_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// ----- sv/pbr_back.sv -----
module pbr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  pbr_pkg::cmd_t              cmd_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pbr_pkg::RUN_W-1:0]  run_offset_o,
  output logic [pbr_pkg::RUN_W-1:0]  run_length_o,
  output logic [pbr_pkg::PATH_W-1:0] run_path_o,
  output logic                       run_valid_o,
  output logic                       last_o,
  output logic                       map_empty_o,
  output logic                       overflow_o
);
  import pbr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FIND = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [PAGES-1:0]  a_q, a_d, b_q, b_d, c_q, c_d;
  logic [PW-1:0]     sa_q, sa_d, sb_q, sb_d, sc_q, sc_d;
  logic [PAGES-1:0]  work_q, work_d, low_q, low_d;
  logic [PW-1:0]     s_q, s_d;
  logic [PATH_W-1:0] path_q, path_d;
  logic [SHW-1:0]    shift_q, shift_d;

  logic              ov_q, ov_d;
  logic [RUN_W-1:0]  off_q, off_d, len_q, len_d;
  logic [PATH_W-1:0] rpath_q, rpath_d;
  logic              rv_q, rv_d, last_q, last_d, emp_q, emp_d, ovf_q, ovf_d;

  logic              out_free, load;
  logic [PAGES-1:0]  sel_bits, new_bits, both, w;
  logic [PW-1:0]     sel_size, new_size, n;
  logic [PAGES:0]    t;
  logic [PW-1:0]     e;
  logic [PAGES-1:0]  rem;

  assign out_free = !ov_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && !q_empty_i && out_free;

  always_comb begin
    case (cmd_i.sel)
      MAP_A:   begin sel_bits = a_q; sel_size = sa_q; end
      MAP_B:   begin sel_bits = b_q; sel_size = sb_q; end
      MAP_C:   begin sel_bits = c_q; sel_size = sc_q; end
      default: begin sel_bits = '0;  sel_size = '0;   end
    endcase
    new_bits = sel_bits | (thermo(cmd_i.stop) & ~thermo(cmd_i.start));
    new_size = (sel_size < cmd_i.endp) ? cmd_i.endp : sel_size;
    n        = (sa_q < sb_q) ? sa_q : sb_q;
    both     = a_q & b_q & thermo(n);
    w        = sel_bits & thermo(sel_size);
    // adding the lowest set bit clears the run and sets the page after it
    t        = {1'b0, work_q} + {1'b0, low_q};
    e        = onehot_idx(t & ~{1'b0, work_q});
    rem      = work_q & t[PAGES-1:0];
  end

  always_comb begin
    state_d = state_q;
    a_d = a_q;  b_d = b_q;  c_d = c_q;
    sa_d = sa_q; sb_d = sb_q; sc_d = sc_q;
    work_d  = work_q;
    low_d   = low_q;
    s_d     = s_q;
    path_d  = path_q;
    shift_d = shift_q;
    load    = 1'b0;
    off_d   = off_q;  len_d = len_q;  rpath_d = rpath_q;
    rv_d    = rv_q;   last_d = last_q; emp_d = emp_q; ovf_d = ovf_q;

    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          load    = 1'b1;
          off_d   = '0;
          len_d   = '0;
          rpath_d = '0;
          rv_d    = 1'b0;
          last_d  = 1'b1;
          emp_d   = 1'b1;
          ovf_d   = 1'b0;
          case (cmd_i.op)
            OP_CLEAR: begin
              case (cmd_i.sel)
                MAP_A:   begin a_d = '0; sa_d = '0; end
                MAP_B:   begin b_d = '0; sb_d = '0; end
                MAP_C:   begin c_d = '0; sc_d = '0; end
                default: ;
              endcase
            end
            OP_MARK: begin
              case (cmd_i.sel)
                MAP_A:   begin a_d = new_bits; sa_d = new_size; end
                MAP_B:   begin b_d = new_bits; sb_d = new_size; end
                MAP_C:   begin c_d = new_bits; sc_d = new_size; end
                default: ;
              endcase
              emp_d = ~|(new_bits & thermo(new_size));
              ovf_d = cmd_i.ovf;
            end
            OP_ISECT: begin
              a_d   = a_q & ~both;
              b_d   = b_q & ~both;
              c_d   = both;
              sc_d  = n;
              emp_d = ~|both;
            end
            OP_EMIT: begin
              if (|w) begin
                // hold the status word back; runs follow from the scan
                load    = 1'b0;
                work_d  = w;
                path_d  = cmd_i.path;
                shift_d = cmd_i.shift;
                state_d = ST_FIND;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FIND: begin
        low_d   = work_q & (~work_q + {{(PAGES-1){1'b0}}, 1'b1});
        s_d     = onehot_idx({1'b0, work_q & (~work_q + {{(PAGES-1){1'b0}}, 1'b1})});
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          load    = 1'b1;
          off_d   = RUN_W'(s_q) << shift_q;
          len_d   = RUN_W'(e - s_q) << shift_q;
          rpath_d = path_q;
          rv_d    = 1'b1;
          last_d  = ~|rem;
          emp_d   = 1'b0;
          ovf_d   = 1'b0;
          work_d  = rem;
          state_d = (|rem) ? ST_FIND : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    ov_d = load ? 1'b1 : (ov_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      a_q  <= '0;  b_q  <= '0;  c_q  <= '0;
      sa_q <= '0;  sb_q <= '0;  sc_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      a_q  <= a_d;  b_q  <= b_d;  c_q  <= c_d;
      sa_q <= sa_d; sb_q <= sb_d; sc_q <= sc_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    low_q   <= low_d;
    s_q     <= s_d;
    path_q  <= path_d;
    shift_q <= shift_d;
    if (load) begin
      off_q   <= off_d;
      len_q   <= len_d;
      rpath_q <= rpath_d;
      rv_q    <= rv_d;
      last_q  <= last_d;
      emp_q   <= emp_d;
      ovf_q   <= ovf_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign run_offset_o = off_q;
  assign run_length_o = len_q;
  assign run_path_o   = rpath_q;
  assign run_valid_o  = rv_q;
  assign last_o       = last_q;
  assign map_empty_o  = emp_q;
  assign overflow_o   = ovf_q;

endmodule

// ----- sv/pbr_checker.sv -----
module pbr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [pbr_pkg::RUN_W-1:0]  run_offset_o,
  input logic [pbr_pkg::RUN_W-1:0]  run_length_o,
  input logic [pbr_pkg::PATH_W-1:0] run_path_o,
  input logic                       run_valid_o,
  input logic                       last_o,
  input logic                       map_empty_o,
  input logic                       overflow_o
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(run_offset_o)
      && $stable(run_length_o) && $stable(run_path_o) && $stable(last_o))
    else $error("result word changed under stall");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_valid_o |-> run_offset_o == '0 && run_length_o == '0
      && run_path_o == '0 && last_o)
    else $error("status word carries run data or is not last");

  a_run_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_valid_o |-> !map_empty_o && !overflow_o && run_length_o != '0)
    else $error("run word with bad flags or zero length");

  a_ovf_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> !run_valid_o && last_o)
    else $error("overflow on a run word");

endmodule

bind page_bitmap_range_engine pbr_checker u_pbr_checker (.*);
